>>> hdl/epr_pkg.sv
// ----------------------------------------------------------------------------
// Endless potentiometer rotation decoder package
// Shared constants, register indices and the beat, configuration and command types of the decoder.
// ----------------------------------------------------------------------------
package epr_pkg;

	localparam int ADC_BITS  = 10;
	localparam int SAMPLE_W  = ADC_BITS;
	localparam int CFG10_W   = 10;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W     = 16;
	localparam int CHANGE_W  = 14;
	localparam int ROT_W     = 2;
	localparam int DIV_W     = SAMPLE_W + 8;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [CHANGE_W-1:0] CHANGE_MAX = CHANGE_W'(16383);

	localparam logic [ROT_W-1:0] ROT_NONE = 2'd0;
	localparam logic [ROT_W-1:0] ROT_CW   = 2'd1;
	localparam logic [ROT_W-1:0] ROT_CCW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_SCALE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SAFETY_MARGIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_HIGH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY_Q8 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX      = 3'd7;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_a;
		logic [SAMPLE_W-1:0] sample_b;
	} in_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_value;
		logic [CHANGE_W-1:0]     step_change;
		logic [ROT_W-1:0]        rotation;
		logic                    moving;
	} out_t;

	typedef struct packed {
		logic [CFG10_W-1:0]      move_threshold;
		logic [CFG10_W-1:0]      half_scale;
		logic [CFG10_W-1:0]      safety_margin;
		logic [CFG10_W-1:0]      linear_low;
		logic [CFG10_W-1:0]      linear_high;
		logic [CFG_W-1:0]        sensitivity_q8;
		logic signed [POS_W-1:0] value_min;
		logic signed [POS_W-1:0] value_max;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

>>> hdl/epr_cfg.sv
// ----------------------------------------------------------------------------
// Configuration register file
// Holds the eight decoder settings and takes writes by register index.
// ----------------------------------------------------------------------------
module epr_cfg (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [epr_pkg::CFG_W-1:0]     cfg_data,
	output epr_pkg::cfg_t            cfg
);
	import epr_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_threshold <= CFG10_W'(4);
			cfg_q.half_scale     <= CFG10_W'(512);
			cfg_q.safety_margin  <= CFG10_W'(64);
			cfg_q.linear_low     <= CFG10_W'(205);
			cfg_q.linear_high    <= CFG10_W'(818);
			cfg_q.sensitivity_q8 <= CFG_W'(256);
			cfg_q.value_min      <= POS_W'(0);
			cfg_q.value_max      <= POS_W'(1023);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MOVE_THRESHOLD: cfg_q.move_threshold <= cfg_data[CFG10_W-1:0];
				REG_HALF_SCALE:     cfg_q.half_scale     <= cfg_data[CFG10_W-1:0];
				REG_SAFETY_MARGIN:  cfg_q.safety_margin  <= cfg_data[CFG10_W-1:0];
				REG_LINEAR_LOW:     cfg_q.linear_low     <= cfg_data[CFG10_W-1:0];
				REG_LINEAR_HIGH:    cfg_q.linear_high    <= cfg_data[CFG10_W-1:0];
				REG_SENSITIVITY_Q8: cfg_q.sensitivity_q8 <= cfg_data;
				REG_VALUE_MIN:      cfg_q.value_min      <= signed'(cfg_data);
				REG_VALUE_MAX:      cfg_q.value_max      <= signed'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/epr_ctrl.sv
// ----------------------------------------------------------------------------
// Decoder controller
// Sequences load, decode, the bit-serial division and the final update.
// ----------------------------------------------------------------------------
module epr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  epr_pkg::sts_t sts,
	output epr_pkg::cmd_t cmd
);
	import epr_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_DECODE = 2'd1;
	localparam logic [1:0] S_DIV    = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

	logic [1:0]       state_q;
	logic [1:0]       state_d;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_step) begin
				cnt_q <= (cnt_q == DIV_LAST) ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/epr_dp.sv
// ----------------------------------------------------------------------------
// Decoder datapath
// Direction decode, restoring divider, clamped accumulator and output register.
// ----------------------------------------------------------------------------
module epr_dp (
	input  logic          clk,
	input  logic          arst_n,
	input  epr_pkg::cfg_t cfg,
	input  epr_pkg::cmd_t cmd,
	output epr_pkg::sts_t sts,
	input  epr_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output epr_pkg::out_t out_data
);
	import epr_pkg::*;

	localparam int CMP_W = ((SAMPLE_W > CFG10_W) ? SAMPLE_W : CFG10_W) + 2;
	localparam int ACC_W = POS_W + 2;

	logic [SAMPLE_W-1:0]     a_q, b_q;
	logic [SAMPLE_W-1:0]     last_a_q, last_b_q;
	logic [ROT_W-1:0]        last_rot_q;
	logic signed [POS_W-1:0] acc_q;
	logic [ROT_W-1:0]        rot_q;
	logic [CFG_W-1:0]        rem_q;
	logic [DIV_W-1:0]        quo_q, dvd_q;
	logic                    out_valid_q;
	out_t                    out_q;

	logic [CMP_W-1:0] a_x, b_x, pa_x, pb_x, thr_x, half_x, mar_x, llo_x, lhi_x;
	logic             a_up, a_dn, b_up, b_dn, near, lin;
	logic [ROT_W-1:0] rot_d;
	logic [SAMPLE_W-1:0] mag_d;

	assign a_x    = CMP_W'(a_q);
	assign b_x    = CMP_W'(b_q);
	assign pa_x   = CMP_W'(last_a_q);
	assign pb_x   = CMP_W'(last_b_q);
	assign thr_x  = CMP_W'(cfg.move_threshold);
	assign half_x = CMP_W'(cfg.half_scale);
	assign mar_x  = CMP_W'(cfg.safety_margin);
	assign llo_x  = CMP_W'(cfg.linear_low);
	assign lhi_x  = CMP_W'(cfg.linear_high);

	assign a_up = a_x > pa_x + thr_x;
	assign a_dn = a_x + thr_x < pa_x;
	assign b_up = b_x > pb_x + thr_x;
	assign b_dn = b_x + thr_x < pb_x;
	assign near = (pb_x < mar_x) || (pb_x + mar_x > half_x);
	assign lin  = (a_x < lhi_x) && (a_x > llo_x);

	always_comb begin
		if (a_dn && b_dn) begin
			rot_d = (a_x > b_x) ? ROT_CW : ROT_CCW;
		end else if (a_up && b_up) begin
			rot_d = (a_x < b_x) ? ROT_CW : ROT_CCW;
		end else if (a_up && b_dn) begin
			if (a_x > half_x || b_x > half_x) begin
				rot_d = (pa_x < half_x && near) ? last_rot_q : ROT_CW;
			end else begin
				rot_d = ROT_CCW;
			end
		end else if (a_dn && b_up) begin
			if (a_x < half_x || b_x < half_x) begin
				rot_d = (pa_x > half_x && near) ? last_rot_q : ROT_CW;
			end else begin
				rot_d = ROT_CCW;
			end
		end else begin
			rot_d = ROT_NONE;
		end
	end

	always_comb begin
		if (lin) begin
			mag_d = (a_q >= last_a_q) ? a_q - last_a_q : last_a_q - a_q;
		end else begin
			mag_d = (b_q >= last_b_q) ? b_q - last_b_q : last_b_q - b_q;
		end
	end

	// One quotient bit per cycle, most significant first.
	logic [CFG_W:0] trial;
	logic           fits;

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, cfg.sensitivity_q8};

	logic                    moving;
	logic [CHANGE_W-1:0]     chg;
	logic signed [ACC_W-1:0] acc_x, chg_x, sum_x, min_x, max_x;
	logic signed [POS_W-1:0] pos_d;

	assign moving = rot_q != ROT_NONE;

	always_comb begin
		if (!moving) begin
			chg = '0;
		end else if (quo_q > DIV_W'(CHANGE_MAX)) begin
			chg = CHANGE_MAX;
		end else begin
			chg = quo_q[CHANGE_W-1:0];
		end
	end

	assign acc_x = ACC_W'(acc_q);
	assign chg_x = signed'(ACC_W'(chg));
	assign min_x = ACC_W'(cfg.value_min);
	assign max_x = ACC_W'(cfg.value_max);

	always_comb begin
		case (rot_q)
			ROT_CW:  sum_x = acc_x + chg_x;
			ROT_CCW: sum_x = acc_x - chg_x;
			default: sum_x = acc_x;
		endcase
		if (!moving) begin
			pos_d = acc_q;
		end else if (sum_x < min_x) begin
			pos_d = cfg.value_min;
		end else if (sum_x > max_x) begin
			pos_d = cfg.value_max;
		end else begin
			pos_d = sum_x[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= in_data.sample_a;
			b_q <= in_data.sample_b;
		end
		if (cmd.decode) begin
			rot_q <= rot_d;
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {mag_d, 8'b0};
		end else if (cmd.div_step) begin
			rem_q <= fits ? CFG_W'(trial - {1'b0, cfg.sensitivity_q8}) : trial[CFG_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
		if (cmd.finish) begin
			out_q.position_value <= pos_d;
			out_q.step_change    <= chg;
			out_q.rotation       <= rot_q;
			out_q.moving         <= moving;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q    <= '0;
			last_b_q    <= '0;
			last_rot_q  <= ROT_NONE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				last_a_q <= a_q;
				last_b_q <= b_q;
				acc_q    <= pos_d;
				if (moving) begin
					last_rot_q <= rot_q;
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule

>>> hdl/endless_pot_rotation_decoder_unit.sv
// ----------------------------------------------------------------------------
// Endless potentiometer rotation decoder
// Turns wiper sample pairs into rotation direction, step and clamped position.
//
// The input channel takes one beat per sample pair of wipers A and B; the
// output channel gives one beat per input beat with the position, the step
// applied, the rotation code and the moving flag. Both use valid and ready.
// An accepted beat is registered at the accepting edge, then passes through
// direction decode, the restoring divider that scales the step by the
// sensitivity, one bit per cycle, and the final update, which raises
// out_valid. One beat is in work at a time and the next can be taken in the
// cycle after the final update of the last. A finished result waits in the
// output register while the next beat is taken; if the receiver has not
// taken it when the next beat is done, the block holds before its final
// update until that register is free.
// Reset restores the register defaults and clears the previous samples, the
// last direction and the position. Configuration writes take effect at once
// and must be made only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module endless_pot_rotation_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  epr_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output epr_pkg::out_t                 out_data,
	input  logic                          cfg_we,
	input  logic [epr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [epr_pkg::CFG_W-1:0]     cfg_data
);
	import epr_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	epr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	epr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	epr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
